### hdl/fbsw_pkg.sv
// Shared types, constants and pixel format helpers for the RGB565 span writer.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package fbsw_pkg;

    // Framebuffer size in 16-bit words (default)
    localparam int unsigned FB_WORDS_DEFAULT = 262144;

    // Field widths
    localparam int unsigned FUNC_W    = 2;
    localparam int unsigned COORD_W   = 10;
    localparam int unsigned COLOUR_W  = 32;
    localparam int unsigned RGB_W     = 24;
    localparam int unsigned PIX_W     = 16;
    localparam int unsigned BPL_W     = 12;
    localparam int unsigned PITCH_W   = BPL_W - 1;
    localparam int unsigned BASE_W    = COORD_W + PITCH_W;
    // y * pitch + x never exceeds 22 bits
    localparam int unsigned ADDR_SUM_W = BASE_W + 1;

    // Stream packing
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned M_TDATA_W = 32;

    // Line pitch after reset, in pixels (1024 bytes)
    localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(512);

    // Command codes
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_HLINE = 2'd2;

    // Colour value that inverts the stored pixels
    localparam logic [COLOUR_W-1:0] INVERT_CODE = 32'hFFFF_FFFF;

    // Controller states
    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_PIXEL  = 5'b00100,
        ST_SECOND = 5'b01000,
        ST_FINISH = 5'b10000
    } fsm_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;   // write one zero word of the clear pass
        logic load;       // capture an accepted command
        logic pix_issue;  // address one pixel: paint, or start a read
        logic rmw;        // second half: write inverted word / capture read
        logic x_step;     // advance to next column of the span
        logic out_load;   // move the finished result to the output register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic              clr_last;
        logic [FUNC_W-1:0] func;
        logic              needs_read;
        logic              span_done;
        logic              out_free;
    } dp_stat_t;

    // 24-bit 0x00RRGGBB to RGB565
    function automatic logic [PIX_W-1:0] pack565(input logic [COLOUR_W-1:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

    // RGB565 to 0x00RRGGBB with zero-filled low bits
    function automatic logic [RGB_W-1:0] unpack565(input logic [PIX_W-1:0] p);
        return {p[15:11], 3'b000, p[10:5], 2'b00, p[4:0], 3'b000};
    endfunction

endpackage

`default_nettype wire

### hdl/fbsw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fbsw_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/fbsw_ctrl.sv
// Sequencer for the span writer: clear pass, command decode, pixel loop.
// Depends on fbsw_pkg; drives the datapath only through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module fbsw_ctrl
    import fbsw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_stat_t   stat,
    output dp_cmd_t         cmd,
    output fsm_state_t      state
);

    fsm_state_t state_reg, state_next;

    assign state    = state_reg;
    assign s_tready = (state_reg == ST_IDLE);

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PIXEL;
                end
            end
            ST_PIXEL: begin
                case (stat.func)
                    FUNC_PUT: begin
                        cmd.pix_issue = 1'b1;
                        state_next    = stat.needs_read ? ST_SECOND : ST_FINISH;
                    end
                    FUNC_GET: begin
                        cmd.pix_issue = 1'b1;
                        state_next    = ST_SECOND;
                    end
                    FUNC_HLINE: begin
                        if (stat.span_done) begin
                            state_next = ST_FINISH;
                        end else begin
                            cmd.pix_issue = 1'b1;
                            if (stat.needs_read) begin
                                state_next = ST_SECOND;
                            end else begin
                                cmd.x_step = 1'b1;
                            end
                        end
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SECOND: begin
                cmd.rmw = 1'b1;
                if (stat.func == FUNC_HLINE) begin
                    cmd.x_step = 1'b1;
                    state_next = ST_PIXEL;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/fbsw_datapath.sv
// Datapath: pitch register, address arithmetic, framebuffer RAM, result register.
// Depends on fbsw_pkg and fbsw_ram; steered by fbsw_ctrl via dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module fbsw_datapath
    import fbsw_pkg::*;
#(
    parameter int unsigned FB_WORDS = FB_WORDS_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // command input payload
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [FUNC_W-1:0]    s_tuser,
    // result output
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,
    // configuration
    input  wire logic                 cfg_valid,
    input  wire logic [BPL_W-1:0]     cfg_data,
    // control
    input  wire dp_cmd_t              cmd,
    output dp_stat_t                  stat
);

    localparam int unsigned AW = $clog2(FB_WORDS);
    localparam logic [ADDR_SUM_W:0] FB_LIMIT = (ADDR_SUM_W + 1)'(FB_WORDS);
    localparam logic [AW-1:0]       LAST_WORD = AW'(FB_WORDS - 1);

    // Unpack the input transfer
    logic [COORD_W-1:0]  in_xs, in_xe, in_y;
    logic [COLOUR_W-1:0] in_colour;

    assign in_xs     = s_tdata[COORD_W-1:0];
    assign in_xe     = s_tdata[2*COORD_W-1:COORD_W];
    assign in_y      = s_tdata[3*COORD_W-1:2*COORD_W];
    assign in_colour = s_tdata[3*COORD_W+COLOUR_W-1:3*COORD_W];

    logic [PITCH_W-1:0] pitch_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [FUNC_W-1:0]  func_reg;
    logic [COORD_W-1:0] x_cur_reg, x_hi_reg;
    logic [BASE_W-1:0]  base_reg;
    logic               invert_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic               outside_reg;
    logic [RGB_W-1:0]   rd_colour_reg;
    logic [AW-1:0]      pend_addr_reg;
    logic               pend_oob_reg;
    logic               m_valid_reg;
    logic [RGB_W-1:0]   m_colour_reg;
    logic               m_status_reg;

    // Line pitch in pixels; the low byte bit is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg <= PITCH_RESET;
        end else if (cfg_valid) begin
            pitch_reg <= cfg_data[BPL_W-1:1];
        end
    end

    // Clear pass address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // Pixel address and bounds check
    logic [ADDR_SUM_W-1:0] pix_addr;
    logic                  pix_oob;
    logic                  needs_read;

    assign pix_addr   = {1'b0, base_reg} + ADDR_SUM_W'(x_cur_reg);
    assign pix_oob    = {1'b0, pix_addr} >= FB_LIMIT;
    assign needs_read = invert_reg || (func_reg == FUNC_GET);

    // Command capture and per-pixel bookkeeping
    logic [COORD_W-1:0] lo_x, hi_x;

    assign lo_x = (in_xs < in_xe) ? in_xs : in_xe;
    assign hi_x = (in_xs < in_xe) ? in_xe : in_xs;

    logic [PIX_W-1:0] ram_rdata;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg      <= s_tuser;
            x_cur_reg     <= (s_tuser == FUNC_HLINE) ? lo_x : in_xs;
            x_hi_reg      <= hi_x;
            base_reg      <= BASE_W'(in_y * pitch_reg);
            invert_reg    <= (in_colour == INVERT_CODE);
            pix_reg       <= pack565(in_colour);
            outside_reg   <= 1'b0;
            rd_colour_reg <= '0;
        end else begin
            if (cmd.pix_issue) begin
                pend_addr_reg <= pix_addr[AW-1:0];
                pend_oob_reg  <= pix_oob;
                if (pix_oob) begin
                    outside_reg <= 1'b1;
                end
            end
            if (cmd.rmw && !pend_oob_reg && (func_reg == FUNC_GET)) begin
                rd_colour_reg <= unpack565(ram_rdata);
            end
            if (cmd.x_step) begin
                x_cur_reg <= x_cur_reg + COORD_W'(1);
            end
        end
    end

    // RAM port steering
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr;
    logic [PIX_W-1:0] ram_wdata;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pix_addr[AW-1:0];
        ram_wdata = pix_reg;
        if (cmd.clr_step) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else if (cmd.rmw) begin
            ram_we    = !pend_oob_reg && (func_reg != FUNC_GET);
            ram_waddr = pend_addr_reg;
            ram_wdata = ~ram_rdata;
        end else if (cmd.pix_issue) begin
            ram_we    = !pix_oob && !needs_read;
        end
    end

    assign ram_re = cmd.pix_issue && !pix_oob && needs_read;

    fbsw_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FB_WORDS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pix_addr[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_colour_reg <= rd_colour_reg;
            m_status_reg <= outside_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - RGB_W - 1)'(0), m_status_reg, m_colour_reg};

    // Status to the controller
    assign stat.clr_last   = (clr_addr_reg == LAST_WORD);
    assign stat.func       = func_reg;
    assign stat.needs_read = needs_read;
    assign stat.span_done  = (x_cur_reg >= x_hi_reg);
    assign stat.out_free   = !m_valid_reg || m_tready;

endmodule

`default_nettype wire

### hdl/rgb565_framebuffer_span_writer_unit.sv
// Top level of the RGB565 framebuffer pixel and span writer.
// Depends on fbsw_pkg, fbsw_ctrl, fbsw_datapath (which holds fbsw_ram).
//
//  Channel   Dir  Signals                        Contents
//  --------  ---  -----------------------------  ----------------------------------
//  command   in   s_tvalid s_tready s_tdata      one drawing command per transfer
//                 s_tuser                        (put, get or horizontal line)
//  result    out  m_tvalid m_tready m_tdata      one result per command
//  config    in   cfg_valid cfg_ready cfg_data   line pitch in bytes
//
// After reset a clear pass zeroes the framebuffer, one word per cycle; commands are
// held off until it ends, configuration is taken at any time.
// After acceptance a command runs the pixel step, a second step for a get or an
// inversion (per pixel for a line), and the finish step, which then returns to idle.
// The single RAM port pair sets the pace; inversion needs a read then a write.
// A waiting result holds the next command in its finish step, not at its transfer.
`timescale 1ns / 1ps
`default_nettype none

module rgb565_framebuffer_span_writer_unit
    import fbsw_pkg::*;
#(
    parameter int unsigned FB_WORDS = FB_WORDS_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // command input
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // x_start, x_end, y_row, colour, zero pad
    input  wire logic [FUNC_W-1:0]    s_tuser,   // func
    // result output
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // read_colour, status, zero pad
    // configuration write
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [BPL_W-1:0]     cfg_data   // bytes_per_line
);

    dp_cmd_t    cmd;
    dp_stat_t   stat;
    fsm_state_t state;

    assign cfg_ready = 1'b1;

    fbsw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd),
        .state    (state)
    );

    fbsw_datapath #(
        .FB_WORDS (FB_WORDS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    // No result may appear before the clear pass has finished
    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ST_CLEAR) |-> !m_tvalid)
        else $error("result presented during clear pass");

    // A new result only comes out of the finish step
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> $past(state == ST_FINISH))
        else $error("result loaded outside finish step");

    // An accepted command goes straight to pixel work
    a_accept_to_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state == ST_PIXEL))
        else $error("accepted command not started");

    // Commands are never taken in the first cycle after reset
    a_hold_after_reset: assert property (@(posedge aclk)
        ($past(!aresetn) && aresetn) |-> !s_tready)
        else $error("command accepted before clear pass");

endmodule

`default_nettype wire
